// ===== hdl/tnba_pkg.sv =====
// Package for the triangle normal best alignment block.
// Types and constants shared by the block's modules and its testbench; no dependencies.
package tnba_pkg;

	localparam int CoordW = 16;
	localparam int CrossW = 35;
	localparam int MagW   = 34;
	localparam int NormW  = 31;
	localparam int SqW    = 64;
	localparam int RootW  = 32;
	localparam int QuotW  = 16;
	localparam int ScoreW = 15;
	localparam logic [ScoreW-1:0] SatQ15 = 15'h7FFF;

	typedef logic signed [CoordW-1:0] coord_t;

	// request layouts, first field at the top bits
	typedef struct packed {
		coord_t a_x, a_y, a_z;
		coord_t b_x, b_y, b_z;
		coord_t c_x, c_y, c_z;
		logic   final_triangle;
	} tri_req_t;

	typedef struct packed {
		coord_t            normal_x, normal_y, normal_z;
		logic [ScoreW-1:0] alignment;
		logic              found;
	} mesh_res_t;

	typedef struct packed {
		logic load;
		logic norm_step;
		logic sq_step;
		logic root_step;
		logic div_start;
		logic div_step;
		logic div_save;
		logic score;
		logic update;
		logic emit;
		logic [1:0] comp;
	} tnba_cmd_t;

	typedef struct packed {
		logic zero;
		logic norm_done;
		logic root_last;
		logic div_last;
		logic final_tri;
	} tnba_sts_t;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_NORM  = 9'b000000010,
		ST_SQ    = 9'b000000100,
		ST_ROOT  = 9'b000001000,
		ST_DIVI  = 9'b000010000,
		ST_DIV   = 9'b000100000,
		ST_SCORE = 9'b001000000,
		ST_UPD   = 9'b010000000,
		ST_OUT   = 9'b100000000
	} tnba_state_t;

endpackage

// ===== hdl/tnba_if.sv =====
// Valid/ready channel interface with a generic payload.
// Depends on nothing; payload type is set by parameter.
interface tnba_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/tnba_ctrl.sv =====
// Controller state machine of the best alignment block.
// Depends on tnba_pkg; drives the datapath through tnba_cmd_t.
module tnba_ctrl import tnba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  tnba_sts_t sts,
	output tnba_cmd_t cmd
);
	tnba_state_t state_q;
	logic [1:0]  cnt_q;
	logic        ovalid_q;

	assign in_ready  = (state_q == ST_IDLE) && !ovalid_q;
	assign out_valid = ovalid_q;

	always_comb begin
		cmd = '0;
		cmd.comp = cnt_q;
		case (state_q)
			ST_IDLE:  cmd.load = in_valid && in_ready;
			ST_NORM:  cmd.norm_step = 1'b1;
			ST_SQ:    cmd.sq_step = 1'b1;
			ST_ROOT:  cmd.root_step = 1'b1;
			ST_DIVI:  cmd.div_start = 1'b1;
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cmd.div_save = sts.div_last;
			end
			ST_SCORE: cmd.score = 1'b1;
			ST_UPD:   cmd.update = 1'b1;
			ST_OUT:   cmd.emit = 1'b1;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid && in_ready) state_q <= ST_NORM;
				ST_NORM: begin
					if (sts.zero) state_q <= ST_SCORE;
					else if (sts.norm_done) state_q <= ST_SQ;
				end
				ST_SQ: begin
					state_q <= ST_ROOT;
					cnt_q   <= '0;
				end
				ST_ROOT: begin
					if (sts.root_last) begin
						state_q <= ST_DIVI;
						cnt_q   <= '0;
					end
				end
				ST_DIVI: state_q <= ST_DIV;
				ST_DIV: begin
					if (sts.div_last) begin
						if (cnt_q == 2'd2) state_q <= ST_SCORE;
						else state_q <= ST_DIVI;
						cnt_q <= cnt_q + 2'd1;
					end
				end
				ST_SCORE: state_q <= ST_UPD;
				ST_UPD: begin
					cnt_q <= '0;
					if (sts.final_tri) state_q <= ST_OUT;
					else state_q <= ST_IDLE;
				end
				ST_OUT: begin
					ovalid_q <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_one_hot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_NORM) else $error("load without start");
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> ovalid_q) else $error("emit lost");
endmodule

// ===== hdl/tnba_dp.sv =====
// Datapath: cross product, scaling, square root, divide, score and best keeper.
// Depends on tnba_pkg; controlled by tnba_ctrl through tnba_cmd_t.
module tnba_dp import tnba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  tnba_cmd_t cmd,
	output tnba_sts_t sts,
	input  coord_t    a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
	input  logic      final_triangle,
	input  coord_t    sight_x, sight_y, sight_z,
	output coord_t    normal_x, normal_y, normal_z,
	output logic [ScoreW-1:0] alignment,
	output logic      found
);
	logic signed [CrossW-1:0] cr_q [3];
	logic [MagW-1:0]  u_q [3];
	logic [SqW-1:0]   sq_q;
	logic [RootW+1:0] racc_q;
	logic [RootW-1:0] root_q;
	logic [4:0]       rcnt_q;
	logic [QuotW:0]   num_q;
	logic [RootW-1:0] drem_q;
	logic [QuotW-1:0] quo_q;
	logic [4:0]       dcnt_q;
	coord_t           n_q [3];
	logic             fin_q;
	logic             ld_d_q;
	logic [ScoreW-1:0] sc_q, best_sc_q;
	coord_t           best_q [3];
	logic             have_q;
	coord_t           onx_q, ony_q, onz_q;
	logic [ScoreW-1:0] oal_q;
	logic             ofd_q;

	logic signed [16:0] d1 [3], d2 [3];
	logic signed [33:0] xp [6];
	logic [MagW-1:0]  m;
	logic [29:0]      ucur;
	logic [59:0]      usq [3];
	logic [RootW+1:0] rtrial;
	logic [RootW+3:0] rcat, rdiff;
	logic             rge;
	logic [RootW:0]   dtry, ddiff;
	logic             dge;
	logic [QuotW:0]   qfin;
	logic [ScoreW-1:0] qsat;
	logic signed [33:0] prod [3];
	logic signed [35:0] dot;
	logic [35:0] adot;
	logic [20:0] sc_wide;

	always_comb begin
		d1[0] = 17'(b_x) - 17'(a_x); d1[1] = 17'(b_y) - 17'(a_y); d1[2] = 17'(b_z) - 17'(a_z);
		d2[0] = 17'(c_x) - 17'(a_x); d2[1] = 17'(c_y) - 17'(a_y); d2[2] = 17'(c_z) - 17'(a_z);
		xp[0] = d1[1] * d2[2];
		xp[1] = d1[2] * d2[1];
		xp[2] = d1[2] * d2[0];
		xp[3] = d1[0] * d2[2];
		xp[4] = d1[0] * d2[1];
		xp[5] = d1[1] * d2[0];
		m = u_q[0];
		if (u_q[1] > m) m = u_q[1];
		if (u_q[2] > m) m = u_q[2];
		// magnitudes are still loading in the first scaling cycle
		sts.zero      = !ld_d_q && (m == '0);
		sts.norm_done = !ld_d_q && m[29] && (m[MagW-1:30] == '0);
		sts.root_last = (rcnt_q == 5'd31);
		sts.div_last  = (dcnt_q == 5'd16);
		sts.final_tri = fin_q;
		for (int i = 0; i < 3; i++) usq[i] = u_q[i][29:0] * u_q[i][29:0];
		ucur = u_q[cmd.comp][29:0];
		prod[0] = n_q[0] * sight_x;
		prod[1] = n_q[1] * sight_y;
		prod[2] = n_q[2] * sight_z;
		dot  = 36'(prod[0]) + 36'(prod[1]) + 36'(prod[2]);
		adot = dot[35] ? 36'(-dot) : 36'(dot);
		sc_wide = adot[35:15];
	end

	// Square root: one result bit per cycle, restoring method on 64-bit radicand.
	always_comb begin
		rtrial = {root_q, 2'b01};
		rcat   = {racc_q, sq_q[SqW-1:SqW-2]};
		rge    = (rcat >= {2'b00, rtrial});
		rdiff  = rcat - {2'b00, rtrial};
	end

	// Divide: floor(u * 2^15 / root), 17 quotient bits, last bit taken at save.
	always_comb begin
		dtry  = {drem_q, num_q[QuotW]};
		dge   = (dtry >= {1'b0, root_q});
		ddiff = dtry - {1'b0, root_q};
		qfin  = {quo_q, dge};
		qsat  = (qfin > 17'(SatQ15)) ? SatQ15 : qfin[ScoreW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cr_q[0] <= CrossW'(xp[0]) - CrossW'(xp[1]);
			cr_q[1] <= CrossW'(xp[2]) - CrossW'(xp[3]);
			cr_q[2] <= CrossW'(xp[4]) - CrossW'(xp[5]);
			fin_q <= final_triangle;
		end
		// magnitudes loaded in the cycle after the cross product, then scaled
		if (ld_d_q) begin
			for (int i = 0; i < 3; i++)
				u_q[i] <= cr_q[i][CrossW-1] ? MagW'(-cr_q[i]) : MagW'(cr_q[i]);
		end else if (cmd.norm_step) begin
			for (int i = 0; i < 3; i++) begin
				if (m[MagW-1:30] != '0) u_q[i] <= u_q[i] >> 1;
				else if (!m[29]) u_q[i] <= u_q[i] << 1;
			end
		end
		if (cmd.sq_step) begin
			sq_q   <= 64'(usq[0]) + 64'(usq[1]) + 64'(usq[2]);
			racc_q <= '0;
			root_q <= '0;
			rcnt_q <= '0;
		end
		if (cmd.root_step) begin
			if (rge) begin
				racc_q <= rdiff[RootW+1:0];
				root_q <= {root_q[RootW-2:0], 1'b1};
			end else begin
				racc_q <= rcat[RootW+1:0];
				root_q <= {root_q[RootW-2:0], 1'b0};
			end
			sq_q   <= sq_q << 2;
			rcnt_q <= rcnt_q + 5'd1;
		end
		if (cmd.div_start) begin
			num_q  <= {ucur[1:0], 15'b0};
			drem_q <= 32'(ucur[29:2]);
			quo_q  <= '0;
			dcnt_q <= '0;
		end
		if (cmd.div_step) begin
			if (dge) begin
				drem_q <= ddiff[RootW-1:0];
				quo_q  <= {quo_q[QuotW-2:0], 1'b1};
			end else begin
				drem_q <= dtry[RootW-1:0];
				quo_q  <= {quo_q[QuotW-2:0], 1'b0};
			end
			num_q  <= num_q << 1;
			dcnt_q <= dcnt_q + 5'd1;
		end
		if (cmd.score) sc_q <= (sc_wide > 21'(SatQ15)) ? SatQ15 : sc_wide[ScoreW-1:0];
		if (cmd.emit) begin
			onx_q <= have_q ? best_q[0] : sight_x;
			ony_q <= have_q ? best_q[1] : sight_y;
			onz_q <= have_q ? best_q[2] : sight_z;
			oal_q <= have_q ? best_sc_q : '0;
			ofd_q <= have_q;
		end
	end

	// normal components: cleared per triangle, saturated and signed at save
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 3; i++) n_q[i] <= '0;
		end else if (cmd.div_save) begin
			n_q[cmd.comp] <= cr_q[cmd.comp][CrossW-1] ? -coord_t'({1'b0, qsat})
				: coord_t'({1'b0, qsat});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ld_d_q <= 1'b0;
		else ld_d_q <= cmd.load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			best_sc_q <= '0;
			for (int i = 0; i < 3; i++) best_q[i] <= '0;
		end else if (cmd.emit) begin
			have_q <= 1'b0;
			best_sc_q <= '0;
			for (int i = 0; i < 3; i++) best_q[i] <= '0;
		end else if (cmd.update && (sc_q > best_sc_q)) begin
			have_q <= 1'b1;
			best_sc_q <= sc_q;
			for (int i = 0; i < 3; i++) best_q[i] <= n_q[i];
		end
	end

	assign normal_x = onx_q; assign normal_y = ony_q; assign normal_z = onz_q;
	assign alignment = oal_q; assign found = ofd_q;

	a_best_mono: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && !cmd.emit |=> best_sc_q >= $past(best_sc_q)) else $error("best dropped");
	a_have: assert property (@(posedge clk) disable iff (!arst_n)
		have_q |-> best_sc_q != '0) else $error("have without score");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> !have_q) else $error("not cleared");
endmodule

// ===== hdl/triangle_normal_best_alignment.sv =====
// Top level of the triangle normal best alignment block.
// Depends on tnba_pkg, tnba_if, tnba_ctrl and tnba_dp.
//
// Usage:
//  - tri_in carries one triangle request (vertices a, b, c in Q8.8, plus
//    final_triangle). res_out carries one result request per mesh, raised
//    after the request that has final_triangle set.
//  - Sight vector: three registers, reset value (0, 0, 32767); the user must
//    write them via cfg_we/cfg_idx/cfg_data only while idle (not enforced).
//  - From accept to result valid, a triangle passes through scaling (one
//    shift per cycle), the squares, the square root (one bit per cycle),
//    three divides, then score, update and the output register. Degenerate
//    triangles skip the squares, root and divide.
//  - The pace of triangles is set by the bit-serial square root and the
//    shared restoring divider.
//  - One triangle at a time; tri_in.ready is low while one is in work or a
//    result waits in the output register.
//  - If res_out stalls, the result holds and no new triangle is taken.
//  - Reset clears the best normal, score, flag and the controller.
module triangle_normal_best_alignment import tnba_pkg::*; (
	input logic clk,
	input logic arst_n,
	tnba_if.sink   tri_in,
	tnba_if.source res_out,
	input logic        cfg_we,
	input logic [1:0]  cfg_idx,
	input logic [15:0] cfg_data
);
	localparam logic [1:0] RegSightX = 2'd0;
	localparam logic [1:0] RegSightY = 2'd1;
	localparam logic [1:0] RegSightZ = 2'd2;

	coord_t sight_x_q, sight_y_q, sight_z_q;
	tnba_cmd_t cmd;
	tnba_sts_t sts;

	// sight registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sight_x_q <= '0;
			sight_y_q <= '0;
			sight_z_q <= 16'sd32767;
		end else if (cfg_we) begin
			case (cfg_idx)
				RegSightX: sight_x_q <= cfg_data;
				RegSightY: sight_y_q <= cfg_data;
				RegSightZ: sight_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tnba_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(tri_in.valid), .in_ready(tri_in.ready),
		.out_valid(res_out.valid), .out_ready(res_out.ready),
		.sts, .cmd
	);

	tnba_dp u_dp (
		.clk, .arst_n, .cmd, .sts,
		.a_x(tri_in.data.a_x), .a_y(tri_in.data.a_y), .a_z(tri_in.data.a_z),
		.b_x(tri_in.data.b_x), .b_y(tri_in.data.b_y), .b_z(tri_in.data.b_z),
		.c_x(tri_in.data.c_x), .c_y(tri_in.data.c_y), .c_z(tri_in.data.c_z),
		.final_triangle(tri_in.data.final_triangle),
		.sight_x(sight_x_q), .sight_y(sight_y_q), .sight_z(sight_z_q),
		.normal_x(res_out.data.normal_x), .normal_y(res_out.data.normal_y),
		.normal_z(res_out.data.normal_z), .alignment(res_out.data.alignment),
		.found(res_out.data.found)
	);
endmodule

// ===== dv/tb.sv =====
// Testbench for triangle_normal_best_alignment: random and directed meshes, checked per result.
// Depends on tnba_pkg, tnba_if and the block's RTL.
module tb import tnba_pkg::*; ();

	localparam int SIGHT_X = 0;
	localparam int SIGHT_Y = 1;
	localparam int SIGHT_Z = 2;
	localparam int CycleLimit = 1500000;
	localparam int HoldCycles = 600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_idx = '0;
	logic [15:0] cfg_data = '0;

	always #10 clk = ~clk;

	tnba_if #(.payload_t(tri_req_t)) tri_ch ();
	tnba_if #(.payload_t(mesh_res_t)) res_ch ();

	triangle_normal_best_alignment DUT (
		.clk(clk), .arst_n(arst_n), .tri_in(tri_ch), .res_out(res_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// predictor copy of the sight registers and the running best
	coord_t sight [3];
	logic [ScoreW-1:0] top_score;
	coord_t top_nx, top_ny, top_nz;
	logic top_valid;

	tri_req_t pending_tris[$];
	mesh_res_t expected_meshes[$];

	int errors = 0;
	int tris_sent = 0;
	int meshes_seen = 0;
	int cycles = 0;
	int snd_idle = 12;
	int rcv_idle = 83;
	logic hold_tok = 1'b0;
	logic hold_seen = 1'b0;
	int hold_cnt = 0;

	function automatic longint unsigned root_floor(longint unsigned x);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// unit normal, score against sight, best tracking; one result per mesh end
	task automatic predict_triangle(input tri_req_t t);
		longint d1x, d1y, d1z, d2x, d2y, d2z, dot;
		longint cr [3];
		longint nrm [3];
		longint unsigned u [3];
		longint unsigned m, len2, len, q, score;
		mesh_res_t r;
		d1x = longint'(t.b_x) - longint'(t.a_x);
		d1y = longint'(t.b_y) - longint'(t.a_y);
		d1z = longint'(t.b_z) - longint'(t.a_z);
		d2x = longint'(t.c_x) - longint'(t.a_x);
		d2y = longint'(t.c_y) - longint'(t.a_y);
		d2z = longint'(t.c_z) - longint'(t.a_z);
		cr[0] = d1y * d2z - d1z * d2y;
		cr[1] = d1z * d2x - d1x * d2z;
		cr[2] = d1x * d2y - d1y * d2x;
		for (int i = 0; i < 3; i++) u[i] = cr[i] < 0 ? -cr[i] : cr[i];
		m = u[0];
		if (u[1] > m) m = u[1];
		if (u[2] > m) m = u[2];
		if (m == 0) begin
			for (int i = 0; i < 3; i++) nrm[i] = 0;
		end else begin
			// bring the largest magnitude into [2^29, 2^30)
			while (m >= (64'd1 << 30)) begin
				m >>= 1;
				for (int i = 0; i < 3; i++) u[i] >>= 1;
			end
			while (m < (64'd1 << 29)) begin
				m <<= 1;
				for (int i = 0; i < 3; i++) u[i] <<= 1;
			end
			len2 = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
			len = root_floor(len2);
			for (int i = 0; i < 3; i++) begin
				q = (u[i] << 15) / len;
				if (q > 32767) q = 32767;
				nrm[i] = cr[i] < 0 ? -longint'(q) : longint'(q);
			end
		end
		dot = longint'(sight[SIGHT_X]) * nrm[0] + longint'(sight[SIGHT_Y]) * nrm[1]
			+ longint'(sight[SIGHT_Z]) * nrm[2];
		score = (dot < 0 ? -dot : dot) >> 15;
		if (score > 32767) score = 32767;
		if (score > top_score) begin
			top_score = score[ScoreW-1:0];
			top_nx = nrm[0][15:0];
			top_ny = nrm[1][15:0];
			top_nz = nrm[2][15:0];
			top_valid = 1'b1;
		end
		if (t.final_triangle) begin
			if (top_valid) begin
				r = '{top_nx, top_ny, top_nz, top_score, 1'b1};
			end else begin
				r = '{sight[SIGHT_X], sight[SIGHT_Y], sight[SIGHT_Z], '0, 1'b0};
			end
			expected_meshes.push_back(r);
			top_score = '0;
			top_nx = '0;
			top_ny = '0;
			top_nz = '0;
			top_valid = 1'b0;
		end
	endtask

	// driver: offer pending triangles, predict on each accepted request
	always @(posedge clk) begin : drv
		logic nv;
		tri_req_t nd;
		nv = tri_ch.valid;
		nd = tri_ch.data;
		if (!arst_n) begin
			nv = 1'b0;
		end else begin
			if (tri_ch.valid && tri_ch.ready) begin
				predict_triangle(tri_ch.data);
				tris_sent++;
				nv = 1'b0;
			end
			if (!nv) begin
				if (pending_tris.size() > 0 && $urandom_range(0, 99) >= snd_idle) begin
					nd = pending_tris.pop_front();
					nv = 1'b1;
				end
			end
		end
		tri_ch.valid <= nv;
		tri_ch.data <= nd;
	end

	// idling profile moves with progress: sender light/receiver heavy, swapped, then none
	always @(posedge clk) begin
		if (tris_sent < 320) begin
			snd_idle <= 12;
			rcv_idle <= 83;
		end else if (tris_sent < 640) begin
			snd_idle <= 83;
			rcv_idle <= 12;
		end else begin
			snd_idle <= 0;
			rcv_idle <= 0;
		end
	end

	// monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin : mon
		mesh_res_t want;
		mesh_res_t got;
		got = res_ch.data;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				meshes_seen++;
				if (expected_meshes.size() == 0) begin
					$error("unexpected result: normal %0d %0d %0d alignment %0d found %0d",
						got.normal_x, got.normal_y, got.normal_z, got.alignment, got.found);
					errors++;
				end else begin
					want = expected_meshes.pop_front();
					if (got.normal_x !== want.normal_x) begin
						$error("normal_x expected %0d got %0d", want.normal_x, got.normal_x);
						errors++;
					end
					if (got.normal_y !== want.normal_y) begin
						$error("normal_y expected %0d got %0d", want.normal_y, got.normal_y);
						errors++;
					end
					if (got.normal_z !== want.normal_z) begin
						$error("normal_z expected %0d got %0d", want.normal_z, got.normal_z);
						errors++;
					end
					if (got.alignment !== want.alignment) begin
						$error("alignment expected %0d got %0d", want.alignment, got.alignment);
						errors++;
					end
					if (got.found !== want.found) begin
						$error("found expected %0d got %0d", want.found, got.found);
						errors++;
					end
				end
			end
			// long hold-off on request, counted here
			if (hold_tok != hold_seen) begin
				hold_seen <= hold_tok;
				hold_cnt <= HoldCycles;
				res_ch.ready <= 1'b0;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= rcv_idle);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return coord_t'($signed($urandom_range(0, 64)) - 32);
			3: return coord_t'($signed($urandom_range(0, 2048)) - 1024);
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic tri_req_t mk_tri(input int ax, ay, az, bx, by, bz, cx, cy, cz, fin);
		tri_req_t t;
		t = '{coord_t'(ax), coord_t'(ay), coord_t'(az), coord_t'(bx), coord_t'(by),
			coord_t'(bz), coord_t'(cx), coord_t'(cy), coord_t'(cz), fin[0]};
		return t;
	endfunction

	// random meshes: mostly short, with degenerates and repeats for ties
	task automatic queue_meshes(input int n_tris);
		tri_req_t t, prev;
		int left, sel;
		prev = '0;
		left = 0;
		for (int i = 0; i < n_tris; i++) begin
			if (left == 0) left = $urandom_range(1, 6);
			sel = $urandom_range(0, 19);
			if (sel < 2 && i > 0) begin
				t = prev;
			end else begin
				t = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'b0};
				if (sel == 2) {t.b_x, t.b_y, t.b_z} = {t.a_x, t.a_y, t.a_z};
				if (sel == 3) {t.c_x, t.c_y, t.c_z} = {t.b_x, t.b_y, t.b_z};
			end
			left--;
			// the last triangle of the set always closes a mesh
			t.final_triangle = (left == 0) || (i == n_tris - 1);
			pending_tris.push_back(t);
			prev = t;
		end
	endtask

	task automatic write_sight(input coord_t x, input coord_t y, input coord_t z);
		coord_t v [3];
		v = '{x, y, z};
		for (int i = SIGHT_X; i <= SIGHT_Z; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_idx <= i[1:0];
			cfg_data <= v[i];
			sight[i] = v[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_tris.size() > 0 || tri_ch.valid || expected_meshes.size() > 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	initial begin
		tri_ch.valid = 1'b0;
		tri_ch.data = '0;
		res_ch.ready = 1'b0;
		sight = '{16'sd0, 16'sd0, 16'sd32767};
		top_score = '0;
		top_nx = '0;
		top_ny = '0;
		top_nz = '0;
		top_valid = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed set under the reset sight
		@(negedge clk);
		pending_tris.push_back(mk_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 1));
		pending_tris.push_back(mk_tri(0, 0, 0, 0, 256, 0, 256, 0, 0, 1));
		pending_tris.push_back(mk_tri(-32768, -32768, -32768, 32767, -32768, -32768,
			-32768, 32767, -32768, 1));
		pending_tris.push_back(mk_tri(32767, 32767, 32767, -32768, 32767, 32767,
			32767, -32768, -32768, 1));
		// degenerates only: no winner, sight comes back
		pending_tris.push_back(mk_tri(5, 5, 5, 5, 5, 5, 9, -3, 7, 0));
		pending_tris.push_back(mk_tri(1, 2, 3, 2, 4, 6, 3, 6, 9, 0));
		pending_tris.push_back(mk_tri(-32768, -32768, -32768, -32768, -32768, -32768,
			-32768, -32768, -32768, 1));
		// normal edge-on to sight scores zero
		pending_tris.push_back(mk_tri(0, 0, 0, 256, 0, 0, 0, 0, 256, 1));
		// tie: equal scores, first one kept
		pending_tris.push_back(mk_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 0));
		pending_tris.push_back(mk_tri(0, 0, 0, 0, 256, 0, 256, 0, 0, 0));
		pending_tris.push_back(mk_tri(0, 0, 0, 512, 0, 0, 0, 512, 0, 1));
		// improving then worsening within one mesh
		pending_tris.push_back(mk_tri(0, 0, 0, 256, 0, 0, 0, 256, 256, 0));
		pending_tris.push_back(mk_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 0));
		pending_tris.push_back(mk_tri(0, 0, 0, 256, 0, 256, 0, 256, 0, 1));
		pending_tris.push_back(mk_tri(100, -7, 3, 101, -7, 3, 100, -6, 3, 1));
		pending_tris.push_back(mk_tri(-1, -1, -1, 32767, 0, 0, 0, 0, 32767, 1));
		queue_meshes(110);
		drain();

		write_sight(16'sd32767, 16'sd0, 16'sd0);
		@(negedge clk);
		queue_meshes(130);
		drain();

		write_sight(16'sh8000, 16'sh8000, 16'sh8000);
		@(negedge clk);
		queue_meshes(130);
		// receiver sits out a long stretch while triangles keep coming
		hold_tok = ~hold_tok;
		drain();

		write_sight(16'sd0, 16'sd0, 16'sd0);
		@(negedge clk);
		queue_meshes(100);
		drain();

		write_sight(16'sd23170, -16'sd23170, 16'sd0);
		@(negedge clk);
		queue_meshes(130);
		drain();

		write_sight(16'sd18918, 16'sd18918, -16'sd18918);
		@(negedge clk);
		queue_meshes(120);
		hold_tok = ~hold_tok;
		drain();

		write_sight(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
		@(negedge clk);
		queue_meshes(210);
		drain();

		$display("sent %0d triangles, checked %0d mesh results over 7 sight settings",
			tris_sent, meshes_seen);
		if (errors == 0 && expected_meshes.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, expected_meshes.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/tnba_pkg.sv
hdl/tnba_if.sv
hdl/tnba_ctrl.sv
hdl/tnba_dp.sv
hdl/triangle_normal_best_alignment.sv
dv/tb.sv
